FILE: hw/rtl/sha256_stream_hasher_macros.svh
// Assertion macros for the SHA-256 stream hasher.
// Included by the top level; the macros expect clk and rst_n in scope.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef SYNTH
`define SHASH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SHASH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHASH_ASSERT_IMP(lbl, ante, cons, msg)
`define SHASH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/shash_pkg.sv
// Shared types, constants and helper functions for the SHA-256 stream hasher.
// No dependencies; used by shash_core and sha256_stream_hasher.
package shash_pkg;

  typedef logic [0:7][31:0]  hash_t;
  typedef logic [0:15][31:0] sched_t;

  localparam int unsigned RND_W = 6;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned IDX_W = 3;

  localparam logic [RND_W-1:0] RND_LAST    = 6'd63;
  localparam logic [CNT_W-1:0] CNT_LAST    = 6'd63;
  localparam logic [CNT_W-1:0] LEN_POS     = 6'd56;
  localparam logic [IDX_W-1:0] WORD_LAST   = 3'd7;
  localparam logic [7:0]       PAD_MARK    = 8'h80;
  localparam logic [63:0]      BITS_PER_BYTE = 64'd8;

  localparam hash_t HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [31:0]      digest_word;
    logic [IDX_W-1:0] word_index;
    logic             last_word;
  } out_t;

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       start;
    logic       init;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RND,
    CORE_ADD
  } core_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_PAD,
    ST_OUT
  } seq_state_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    ror32 = (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: hw/rtl/shash_core.sv
// SHA-256 compression core: block shift register, message schedule window,
// one round per cycle, and the chaining value. Depends on shash_pkg.
module shash_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  shash_pkg::core_ctl_t  ctl,
  output shash_pkg::core_sts_t  sts,
  output shash_pkg::hash_t      hv
);

  shash_pkg::core_state_t         state_r, state_nxt;
  logic [shash_pkg::RND_W-1:0]    rnd_r, rnd_nxt;
  shash_pkg::sched_t              win_r, win_nxt;
  shash_pkg::hash_t               work_r, work_nxt;
  shash_pkg::hash_t               hv_r, hv_nxt;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // The block buffer doubles as the schedule window: bytes shift in during
  // gathering, and during rounds word 0 is always the current schedule word.
  assign w_new = win_r[0] + shash_pkg::small_sig0(win_r[1]) + win_r[9] +
                 shash_pkg::small_sig1(win_r[14]);

  assign ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^
               (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + shash_pkg::big_sig1(work_r[4]) + ch +
               shash_pkg::ROUND_K[rnd_r] + win_r[0];
  assign t2  = shash_pkg::big_sig0(work_r[0]) + maj;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shash_pkg::CORE_IDLE: begin
        if (ctl.start) begin
          state_nxt = shash_pkg::CORE_RND;
        end
      end
      shash_pkg::CORE_RND: begin
        if (rnd_r == shash_pkg::RND_LAST) begin
          state_nxt = shash_pkg::CORE_ADD;
        end
      end
      shash_pkg::CORE_ADD: begin
        state_nxt = shash_pkg::CORE_IDLE;
      end
      default: begin
        state_nxt = shash_pkg::CORE_IDLE;
      end
    endcase
  end

  always_comb begin
    sts.busy = (state_r != shash_pkg::CORE_IDLE);
    sts.done = (state_r == shash_pkg::CORE_ADD);
  end

  always_comb begin
    rnd_nxt  = rnd_r;
    win_nxt  = win_r;
    work_nxt = work_r;
    hv_nxt   = hv_r;
    if (ctl.push) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], ctl.push_byte};
    end else if (state_r == shash_pkg::CORE_RND) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = w_new;
    end
    if (ctl.start) begin
      rnd_nxt  = '0;
      work_nxt = hv_r;
    end else if (state_r == shash_pkg::CORE_RND) begin
      rnd_nxt     = rnd_r + 6'd1;
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + t1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = t1 + t2;
    end
    if (ctl.init) begin
      hv_nxt = shash_pkg::HASH_IV;
    end else if (state_r == shash_pkg::CORE_ADD) begin
      for (int j = 0; j < 8; j++) begin
        hv_nxt[j] = hv_r[j] + work_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shash_pkg::CORE_IDLE;
      hv_r    <= shash_pkg::HASH_IV;
    end else begin
      state_r <= state_nxt;
      hv_r    <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r  <= rnd_nxt;
    win_r  <= win_nxt;
    work_r <= work_nxt;
  end

  assign hv = hv_r;

endmodule

FILE: hw/rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher. Byte beats are taken one per cycle while in_ready is
// high; every 64th byte starts a compression (the start state, 64 rounds on the
// shared round unit, then the chaining add), during which in_ready is low. On
// the end mark the padding bytes go into the block one per cycle, followed by
// one or two compressions, and then the digest leaves as eight 32-bit beats,
// most significant word first. The round unit is what sets the rate. After the
// last digest beat the hasher is ready for the next message.
// Depends on shash_pkg, shash_core and sha256_stream_hasher_macros.svh.
`include "sha256_stream_hasher_macros.svh"

module sha256_stream_hasher (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  shash_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output shash_pkg::out_t  out_data
);

  shash_pkg::seq_state_t         state_r, state_nxt;
  logic [shash_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [63:0]                   bitcnt_r, bitcnt_nxt;
  logic [shash_pkg::IDX_W-1:0]   oidx_r, oidx_nxt;
  logic                          last_pend_r, last_pend_nxt;
  logic                          pad_r, pad_nxt;
  logic                          pad80_r, pad80_nxt;
  logic                          zfill_r, zfill_nxt;

  shash_pkg::core_ctl_t ctl;
  shash_pkg::core_sts_t sts;
  shash_pkg::hash_t     hv;

  logic [5:0]  len_sh;
  logic [63:0] len_shift;
  logic        out_fire;
  logic        fills_block;

  shash_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts),
    .hv    (hv)
  );

  // Length bytes go out most significant first at block positions 56..63.
  assign len_sh    = {3'd7 - cnt_r[2:0], 3'b000};
  assign len_shift = bitcnt_r >> len_sh;

  assign out_fire    = out_valid && out_ready;
  assign fills_block = in_data.byte_present && (cnt_r == shash_pkg::CNT_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      shash_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (fills_block) begin
            state_nxt = shash_pkg::ST_START;
          end else if (in_data.is_last) begin
            state_nxt = shash_pkg::ST_PAD;
          end else begin
            state_nxt = shash_pkg::ST_IDLE;
          end
        end
      end
      shash_pkg::ST_START: begin
        state_nxt = shash_pkg::ST_WAIT;
      end
      shash_pkg::ST_WAIT: begin
        if (sts.done) begin
          priority if (pad_r && zfill_r) begin
            state_nxt = shash_pkg::ST_PAD;
          end else if (pad_r) begin
            state_nxt = shash_pkg::ST_OUT;
          end else if (last_pend_r) begin
            state_nxt = shash_pkg::ST_PAD;
          end else begin
            state_nxt = shash_pkg::ST_IDLE;
          end
        end
      end
      shash_pkg::ST_PAD: begin
        if (cnt_r == shash_pkg::CNT_LAST) begin
          state_nxt = shash_pkg::ST_START;
        end
      end
      shash_pkg::ST_OUT: begin
        if (out_ready && (oidx_r == shash_pkg::WORD_LAST)) begin
          state_nxt = shash_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = shash_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctl           = '0;
    cnt_nxt       = cnt_r;
    bitcnt_nxt    = bitcnt_r;
    oidx_nxt      = oidx_r;
    last_pend_nxt = last_pend_r;
    pad_nxt       = pad_r;
    pad80_nxt     = pad80_r;
    zfill_nxt     = zfill_r;
    unique case (state_r)
      shash_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_pend_nxt = in_data.is_last;
          if (in_data.byte_present) begin
            ctl.push      = 1'b1;
            ctl.push_byte = in_data.in_byte;
            cnt_nxt       = cnt_r + 6'd1;
            bitcnt_nxt    = bitcnt_r + shash_pkg::BITS_PER_BYTE;
          end
          if (in_data.is_last && !fills_block) begin
            pad_nxt   = 1'b1;
            pad80_nxt = 1'b1;
          end
        end
      end
      shash_pkg::ST_START: begin
        ctl.start = 1'b1;
      end
      shash_pkg::ST_WAIT: begin
        if (sts.done) begin
          if (pad_r) begin
            zfill_nxt = 1'b0;
          end else if (last_pend_r) begin
            pad_nxt   = 1'b1;
            pad80_nxt = 1'b1;
          end
        end
      end
      shash_pkg::ST_PAD: begin
        ctl.push = 1'b1;
        priority if (pad80_r) begin
          ctl.push_byte = shash_pkg::PAD_MARK;
        end else if (!zfill_r && (cnt_r >= shash_pkg::LEN_POS)) begin
          ctl.push_byte = len_shift[7:0];
        end else begin
          ctl.push_byte = 8'h00;
        end
        // A marker that lands in the last eight positions pushes the length
        // into an extra all-zero block.
        if (pad80_r && (cnt_r >= shash_pkg::LEN_POS)) begin
          zfill_nxt = 1'b1;
        end
        pad80_nxt = 1'b0;
        cnt_nxt   = cnt_r + 6'd1;
      end
      shash_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == shash_pkg::WORD_LAST) begin
            ctl.init      = 1'b1;
            bitcnt_nxt    = '0;
            cnt_nxt       = '0;
            pad_nxt       = 1'b0;
            last_pend_nxt = 1'b0;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_data.digest_word = hv[oidx_r];
    out_data.word_index  = oidx_r;
    out_data.last_word   = (oidx_r == shash_pkg::WORD_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= shash_pkg::ST_IDLE;
      cnt_r       <= '0;
      bitcnt_r    <= '0;
      oidx_r      <= '0;
      last_pend_r <= 1'b0;
      pad_r       <= 1'b0;
      pad80_r     <= 1'b0;
      zfill_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      bitcnt_r    <= bitcnt_nxt;
      oidx_r      <= oidx_nxt;
      last_pend_r <= last_pend_nxt;
      pad_r       <= pad_nxt;
      pad80_r     <= pad80_nxt;
      zfill_r     <= zfill_nxt;
    end
  end

  `SHASH_ASSERT_IMP(a_start_core_idle, ctl.start, !sts.busy, "compression started while busy")
  `SHASH_ASSERT_IMP(a_push_core_idle, ctl.push, !sts.busy, "byte pushed during compression")
  `SHASH_ASSERT_IMP(a_ready_core_idle, in_ready, !sts.busy && !out_valid, "ready while working")
  `SHASH_ASSERT_NXT(a_clean_restart, out_fire && out_data.last_word,
    (bitcnt_r == '0) && (cnt_r == '0) && (hv == shash_pkg::HASH_IV),
    "hasher did not return to the initial state after the digest")

endmodule

FILE: sim/tb.sv
// Self-checking bench for sha256_stream_hasher: streams byte beats, predicts each digest
// with an in-bench SHA-256 model and checks every digest word.
// Depends on shash_pkg and the sha256_stream_hasher RTL.
`timescale 1ns / 100ps

class digest_tracker;
  logic [31:0]     round_k [64];
  logic [31:0]     hash_init [8];
  logic [31:0]     chain [8];
  logic [7:0]      blk [64];
  int              fill;
  logic [63:0]     bit_count;
  shash_pkg::out_t due_words [$];
  int              errors;

  function new();
    round_k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    hash_init = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    errors = 0;
    restart();
  endfunction

  function void restart();
    chain = hash_init;
    fill = 0;
    bit_count = 64'd0;
  endfunction

  function logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int t;
    for (t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    v = chain;
    for (t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (t = 0; t < 8; t++)
      chain[t] = chain[t] + v[t];
  endfunction

  // Absorbs one accepted input beat; an end mark queues the eight digest words.
  function void note_beat(input shash_pkg::in_t beat);
    shash_pkg::out_t word;
    int j;
    if (beat.byte_present) begin
      blk[fill] = beat.in_byte;
      fill++;
      bit_count = bit_count + 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (beat.is_last) begin
      blk[fill] = 8'h80;
      fill++;
      // No room left for the length field: close this block and use another.
      if (fill > 56) begin
        while (fill < 64) begin
          blk[fill] = 8'h00;
          fill++;
        end
        compress();
        fill = 0;
      end
      while (fill < 56) begin
        blk[fill] = 8'h00;
        fill++;
      end
      for (j = 0; j < 8; j++)
        blk[63-j] = bit_count[8*j +: 8];
      compress();
      for (j = 0; j < 8; j++) begin
        word.digest_word = chain[j];
        word.word_index = 3'(j);
        word.last_word = (j == 7);
        due_words.push_back(word);
      end
      restart();
    end
  endfunction

  function void check_word(input shash_pkg::out_t got);
    shash_pkg::out_t exp_w;
    if (due_words.size() == 0) begin
      $error("digest beat %h (index %0d) with no digest pending",
             got.digest_word, got.word_index);
      errors++;
      return;
    end
    exp_w = due_words.pop_front();
    if (got.digest_word !== exp_w.digest_word) begin
      $error("digest_word: expected %h, got %h", exp_w.digest_word, got.digest_word);
      errors++;
    end
    if (got.word_index !== exp_w.word_index) begin
      $error("word_index: expected %0d, got %0d", exp_w.word_index, got.word_index);
      errors++;
    end
    if (got.last_word !== exp_w.last_word) begin
      $error("last_word: expected %0b, got %0b", exp_w.last_word, got.last_word);
      errors++;
    end
  endfunction

  function int words_due();
    return due_words.size();
  endfunction

  function bit close_out();
    if (due_words.size() != 0) begin
      $error("%0d digest words never arrived", due_words.size());
      errors++;
    end
    return errors == 0;
  endfunction
endclass

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 480;
  localparam int CALM_AFTER     = 400;
  localparam int DRAIN_CYCLES   = 300;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  shash_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  shash_pkg::out_t out_data;

  digest_tracker board;
  bit calm         = 1'b0;
  int tx_gap_pct   = 30;
  int rx_stall_pct = 30;
  int sent         = 0;
  int quiet        = 0;

  sha256_stream_hasher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_beat(in_data);
      if (out_valid && out_ready) board.check_word(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else if (quiet == WATCHDOG_LIMIT) begin
        $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("sha256_stream_hasher: mismatch");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Result side: random stall bursts, none once the run turns calm.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (rst_n && !calm && $urandom_range(1, 100) <= rx_stall_pct) begin
        n = $urandom_range(1, 7);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic shash_pkg::in_t beat_of(input logic [7:0] b, input logic p,
                                             input logic l);
    shash_pkg::in_t beat;
    beat.in_byte = b;
    beat.byte_present = p;
    beat.is_last = l;
    return beat;
  endfunction

  // Leaves valid high on return, so back-to-back beats need no extra edge.
  task automatic send_beat(input shash_pkg::in_t beat);
    int n;
    if (!calm && $urandom_range(1, 100) <= tx_gap_pct) begin
      n = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.words_due() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len, input bit end_on_byte);
    int i;
    logic [7:0] b;
    for (i = 0; i < len; i++) begin
      // Beats with neither a byte nor an end mark must leave the state alone.
      if ($urandom_range(0, 9) == 0)
        send_beat(beat_of(8'($urandom), 1'b0, 1'b0));
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_beat(beat_of(b, 1'b1, end_on_byte && (i == len - 1)));
      sent++;
    end
    if (!end_on_byte || len == 0) begin
      send_beat(beat_of(8'($urandom), 1'b0, 1'b1));
      sent++;
    end
  endtask

  initial begin
    int len;
    int msg_no;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(beat_of(8'h00, 1'b0, 1'b1));   // empty message
    send_beat(beat_of(8'hff, 1'b0, 1'b0));
    send_beat(beat_of(8'h00, 1'b1, 1'b1));
    send_beat(beat_of(8'hff, 1'b1, 1'b1));
    send_beat(beat_of(8'h61, 1'b1, 1'b0));
    send_beat(beat_of(8'h62, 1'b1, 1'b0));
    send_beat(beat_of(8'h63, 1'b1, 1'b1));
    send_beat(beat_of(8'haa, 1'b1, 1'b0));
    send_beat(beat_of(8'h55, 1'b1, 1'b0));
    // End mark on a beat without data; its byte lane must be ignored.
    send_beat(beat_of(8'hff, 1'b0, 1'b1));
    send_beat(beat_of(8'h00, 1'b0, 1'b1));
    drain_digests();

    msg_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= CALM_AFTER) calm = 1'b1;
      tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      // The first few lengths sit on the padding edges: one or two final blocks.
      case (msg_no)
        0: len = 55;
        1: len = 56;
        2: len = 64;
        default:
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: len = $urandom_range(0, 12);
            5, 6, 7: len = $urandom_range(54, 65);
            8: len = $urandom_range(13, 130);
            default: len = $urandom_range(118, 129);
          endcase
      endcase
      if (msg_no % 4 == 1 || $urandom_range(0, 4) == 0) drain_digests();
      send_message(len, $urandom_range(0, 1));
      msg_no++;
    end

    drain_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.close_out())
      $display("sha256_stream_hasher: match");
    else
      $display("sha256_stream_hasher: mismatch");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/shash_pkg.sv
hw/rtl/shash_core.sv
hw/rtl/sha256_stream_hasher.sv
sim/tb.sv
